// ----- rtl/rfrot_pkg.sv -----
package rfrot_pkg;

	localparam int ANGLE_BITS = 16;
	localparam int FRAC_BITS  = 16;
	localparam int IN_W       = 16;
	localparam int OUT_W      = FRAC_BITS + 2;
	localparam int ITERS      = 30;
	localparam int XW         = 34;
	localparam int PW         = 36;
	localparam int MW         = 2 * PW;
	localparam int VW         = 40;
	localparam int QDEPTH     = 8;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);
	localparam int RND_SH     = 30 - FRAC_BITS;

	localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(652032874);
	localparam logic signed [PW-1:0] INV_SQRT2   = PW'(759250125);
	localparam logic signed [PW-1:0] Q30_ONE     = PW'(64'd1 << 30);
	localparam logic signed [MW-1:0] HALF_Q30    = MW'(64'd1 << 29);
	localparam logic signed [VW-1:0] RND_ADD     = VW'((64'd1 << RND_SH) >> 1);
	localparam logic signed [VW-1:0] OUT_LIM     = VW'(64'd1 << FRAC_BITS);

	typedef struct packed {
		logic signed [OUT_W-1:0] hp;
		logic signed [OUT_W-1:0] r01;
		logic signed [OUT_W-1:0] r01_n;
		logic signed [OUT_W-1:0] i01;
		logic signed [OUT_W-1:0] i01_n;
		logic signed [OUT_W-1:0] re2;
		logic signed [OUT_W-1:0] im2;
		logic signed [OUT_W-1:0] im2_n;
		logic signed [OUT_W-1:0] cosv;
	} mat_entry_t;

	typedef struct packed {
		logic       valid;
		mat_entry_t data;
	} q_word_t;

	function automatic logic signed [XW-1:0] atan_turn(input int i);
		case (i)
			0:  atan_turn = XW'(536870912);
			1:  atan_turn = XW'(316933406);
			2:  atan_turn = XW'(167458907);
			3:  atan_turn = XW'(85004756);
			4:  atan_turn = XW'(42667331);
			5:  atan_turn = XW'(21354465);
			6:  atan_turn = XW'(10679838);
			7:  atan_turn = XW'(5340245);
			8:  atan_turn = XW'(2670163);
			9:  atan_turn = XW'(1335087);
			10: atan_turn = XW'(667544);
			11: atan_turn = XW'(333772);
			12: atan_turn = XW'(166886);
			13: atan_turn = XW'(83443);
			14: atan_turn = XW'(41722);
			15: atan_turn = XW'(20861);
			16: atan_turn = XW'(10430);
			17: atan_turn = XW'(5215);
			18: atan_turn = XW'(2608);
			19: atan_turn = XW'(1304);
			20: atan_turn = XW'(652);
			21: atan_turn = XW'(326);
			22: atan_turn = XW'(163);
			23: atan_turn = XW'(81);
			24: atan_turn = XW'(41);
			25: atan_turn = XW'(20);
			26: atan_turn = XW'(10);
			27: atan_turn = XW'(5);
			28: atan_turn = XW'(3);
			29: atan_turn = XW'(1);
			default: atan_turn = '0;
		endcase
	endfunction

	function automatic logic signed [PW-1:0] qround(input logic signed [MW-1:0] p);
		logic signed [MW-1:0] t;
		t = (p + HALF_Q30) >>> 30;
		qround = PW'(t);
	endfunction

	function automatic logic signed [OUT_W-1:0] to_out(input logic signed [VW-1:0] v);
		logic signed [VW-1:0] w;
		w = (v + RND_ADD) >>> RND_SH;
		if (w > OUT_LIM) w = OUT_LIM;
		if (w < -OUT_LIM) w = -OUT_LIM;
		to_out = OUT_W'(w);
	endfunction

endpackage

// ----- rtl/rfrot_in_if.sv -----
interface rfrot_in_if import rfrot_pkg::*;;
	logic            valid;
	logic            ready;
	logic [IN_W-1:0] flip_angle;
	logic [IN_W-1:0] pulse_phase;

	modport source(output valid, flip_angle, pulse_phase, input ready);
	modport sink(input valid, flip_angle, pulse_phase, output ready);
endinterface

// ----- rtl/rfrot_out_if.sv -----
interface rfrot_out_if import rfrot_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic [1:0]              row_index;
	logic [1:0]              col_index;
	logic signed [OUT_W-1:0] real_part;
	logic signed [OUT_W-1:0] imag_part;
	logic                    last_entry;

	modport source(output valid, row_index, col_index, real_part, imag_part, last_entry,
		input ready);
	modport sink(input valid, row_index, col_index, real_part, imag_part, last_entry,
		output ready);
endinterface

// ----- rtl/epg_rf_rotation_matrix_core.sv -----
// The first matrix word appears once a pulse has passed the CORDIC pipelines, front stages
// s1 to s4, queue and output register; its nine words leave through the single result
// channel on consecutive cycles while out_word.ready is high, as later pulses wait in queue.
// Three 30-stage CORDIC pipelines take a pulse while ready; an 8-entry queue decouples them.
// Reset clears all valid bits, queue pointers and the entry counter; no clearing pass.
module epg_rf_rotation_matrix_core import rfrot_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	rfrot_in_if.sink    in_word,
	rfrot_out_if.source out_word
);

	q_word_t push;
	q_word_t head;
	logic    pop;

	rfrot_front u_front (
		.clk(clk), .arst_n(arst_n), .in_word(in_word), .pop(pop), .push(push)
	);

	rfrot_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .pop(pop), .head(head)
	);

	rfrot_back u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .pop(pop), .out_word(out_word)
	);

endmodule

// ----- rtl/rfrot_cordic.sv -----
module rfrot_cordic import rfrot_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [31:0]          in_turn,
	output logic                 out_valid,
	output logic signed [XW-1:0] out_cos,
	output logic signed [XW-1:0] out_sin
);

	logic                 v_s    [0:ITERS];
	logic                 flip_s [0:ITERS];
	logic signed [XW-1:0] x_s    [0:ITERS];
	logic signed [XW-1:0] y_s    [0:ITERS];
	logic signed [XW-1:0] z_s    [0:ITERS];

	logic        flip;
	logic [31:0] u;

	assign flip = (in_turn[31:30] == 2'b01) || (in_turn[31:30] == 2'b10);
	assign u    = flip ? (in_turn - 32'h8000_0000) : in_turn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		x_s[0]    <= CORDIC_GAIN;
		y_s[0]    <= '0;
		z_s[0]    <= XW'($signed(u));
		flip_s[0] <= flip;
	end

	for (genvar i = 0; i < ITERS; i++) begin : g_iter
		logic signed [XW-1:0] dx;
		logic signed [XW-1:0] dy;
		logic                 pos;

		assign dx  = y_s[i] >>> i;
		assign dy  = x_s[i] >>> i;
		assign pos = !z_s[i][XW-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			x_s[i+1]    <= pos ? (x_s[i] - dx) : (x_s[i] + dx);
			y_s[i+1]    <= pos ? (y_s[i] + dy) : (y_s[i] - dy);
			z_s[i+1]    <= pos ? (z_s[i] - atan_turn(i)) : (z_s[i] + atan_turn(i));
			flip_s[i+1] <= flip_s[i];
		end
	end

	assign out_valid = v_s[ITERS];
	assign out_cos   = flip_s[ITERS] ? -x_s[ITERS] : x_s[ITERS];
	assign out_sin   = flip_s[ITERS] ? -y_s[ITERS] : y_s[ITERS];

endmodule

// ----- rtl/rfrot_front.sv -----
module rfrot_front import rfrot_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	rfrot_in_if.sink in_word,
	input  logic    pop,
	output q_word_t push
);

	logic [QCNT_W-1:0] used_q;
	logic              fire;
	logic [31:0]       ta;
	logic [31:0]       tp;
	logic [31:0]       t2;

	logic                 cv;
	logic signed [XW-1:0] c_a, s_a, c_p, s_p, c_2, s_2;

	assign in_word.ready = used_q < QCNT_W'(QDEPTH);
	assign fire          = in_word.valid && in_word.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else begin
			used_q <= used_q + QCNT_W'(fire) - QCNT_W'(pop);
		end
	end

	assign ta = 32'(in_word.flip_angle) << (32 - ANGLE_BITS);
	assign tp = 32'(in_word.pulse_phase) << (32 - ANGLE_BITS);
	assign t2 = tp << 1;

	rfrot_cordic u_cordic_a (
		.clk(clk), .arst_n(arst_n), .in_valid(fire), .in_turn(ta),
		.out_valid(cv), .out_cos(c_a), .out_sin(s_a)
	);

	rfrot_cordic u_cordic_p (
		.clk(clk), .arst_n(arst_n), .in_valid(fire), .in_turn(tp),
		.out_valid(), .out_cos(c_p), .out_sin(s_p)
	);

	rfrot_cordic u_cordic_2 (
		.clk(clk), .arst_n(arst_n), .in_valid(fire), .in_turn(t2),
		.out_valid(), .out_cos(c_2), .out_sin(s_2)
	);

	logic                 v_s1, v_s2, v_s3, v_s4;
	logic signed [XW-1:0] c_s1, s_s1, cp_s1, sp_s1, c2_s1, s2_s1;
	logic signed [PW-1:0] hp_s1, hm_s1;
	logic signed [PW-1:0] m1_s2, m2_s2, m3_s2, m4_s2, hp_s2, c_s2;
	logic signed [PW-1:0] r01_s3, i01_s3, m3_s3, m4_s3, hp_s3, c_s3;
	mat_entry_t           data_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= cv;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		c_s1  <= c_a;
		s_s1  <= s_a;
		cp_s1 <= c_p;
		sp_s1 <= s_p;
		c2_s1 <= c_2;
		s2_s1 <= s_2;
		hp_s1 <= (Q30_ONE + PW'(c_a) + PW'(1)) >>> 1;
		hm_s1 <= (Q30_ONE - PW'(c_a) + PW'(1)) >>> 1;

		m1_s2 <= qround(MW'(s_s1) * MW'(sp_s1));
		m2_s2 <= qround(MW'(s_s1) * MW'(cp_s1));
		m3_s2 <= qround(MW'(hm_s1) * MW'(c2_s1));
		m4_s2 <= qround(MW'(hm_s1) * MW'(s2_s1));
		hp_s2 <= hp_s1;
		c_s2  <= PW'(c_s1);

		r01_s3 <= qround(MW'(m1_s2) * MW'(INV_SQRT2));
		i01_s3 <= -qround(MW'(m2_s2) * MW'(INV_SQRT2));
		m3_s3  <= m3_s2;
		m4_s3  <= m4_s2;
		hp_s3  <= hp_s2;
		c_s3   <= c_s2;

		data_s4.hp    <= to_out(VW'(hp_s3));
		data_s4.r01   <= to_out(VW'(r01_s3));
		data_s4.r01_n <= to_out(-VW'(r01_s3));
		data_s4.i01   <= to_out(VW'(i01_s3));
		data_s4.i01_n <= to_out(-VW'(i01_s3));
		data_s4.re2   <= to_out(VW'(m3_s3));
		data_s4.im2   <= to_out(VW'(m4_s3));
		data_s4.im2_n <= to_out(-VW'(m4_s3));
		data_s4.cosv  <= to_out(VW'(c_s3));
	end

	assign push.valid = v_s4;
	assign push.data  = data_s4;

endmodule

// ----- rtl/rfrot_queue.sv -----
module rfrot_queue import rfrot_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  q_word_t push,
	input  logic    pop,
	output q_word_t head
);

	mat_entry_t        mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push.valid) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			cnt_q <= cnt_q + QCNT_W'(push.valid) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) mem[wr_ptr_q] <= push.data;
	end

	assign head.valid = cnt_q != '0;
	assign head.data  = mem[rd_ptr_q];

endmodule

// ----- rtl/rfrot_back.sv -----
module rfrot_back import rfrot_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  q_word_t  head,
	output logic     pop,
	rfrot_out_if.source out_word
);

	logic                    ov_q;
	logic [1:0]              row_q, col_q;
	logic [1:0]              orow_q, ocol_q;
	logic signed [OUT_W-1:0] re_q, im_q;
	logic                    last_q;
	logic                    load;
	logic                    last_pos;
	logic signed [OUT_W-1:0] re_d, im_d;

	assign load     = !ov_q || out_word.ready;
	assign last_pos = (row_q == 2'd2) && (col_q == 2'd2);
	assign pop      = load && head.valid && last_pos;

	always_comb begin
		re_d = head.data.hp;
		im_d = '0;
		case ({row_q, col_q})
			{2'd0, 2'd0}: begin re_d = head.data.hp;    im_d = '0;               end
			{2'd0, 2'd1}: begin re_d = head.data.r01;   im_d = head.data.i01;    end
			{2'd0, 2'd2}: begin re_d = head.data.re2;   im_d = head.data.im2;    end
			{2'd1, 2'd0}: begin re_d = head.data.r01_n; im_d = head.data.i01;    end
			{2'd1, 2'd1}: begin re_d = head.data.cosv;  im_d = '0;               end
			{2'd1, 2'd2}: begin re_d = head.data.r01_n; im_d = head.data.i01_n;  end
			{2'd2, 2'd0}: begin re_d = head.data.re2;   im_d = head.data.im2_n;  end
			{2'd2, 2'd1}: begin re_d = head.data.r01;   im_d = head.data.i01_n;  end
			default:      begin re_d = head.data.hp;    im_d = '0;               end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			row_q <= '0;
			col_q <= '0;
		end else if (load) begin
			ov_q <= head.valid;
			if (head.valid) begin
				if (col_q == 2'd2) begin
					col_q <= '0;
					row_q <= (row_q == 2'd2) ? 2'd0 : row_q + 2'd1;
				end else begin
					col_q <= col_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head.valid) begin
			orow_q <= row_q;
			ocol_q <= col_q;
			re_q   <= re_d;
			im_q   <= im_d;
			last_q <= last_pos;
		end
	end

	assign out_word.valid      = ov_q;
	assign out_word.row_index  = orow_q;
	assign out_word.col_index  = ocol_q;
	assign out_word.real_part  = re_q;
	assign out_word.imag_part  = im_q;
	assign out_word.last_entry = last_q;

endmodule
